// ===== sv/smpd_pkg.sv =====
`default_nettype none
package smpd_pkg;

  localparam int TABLE_POINTS_DEF = 64;

  localparam int SINE_LEN   = 64;
  localparam int SINE_IW    = 6;
  localparam int SAMPLE_W   = 10;
  localparam int MAG_W      = 10;
  localparam int STEPS_W    = 6;
  localparam int SCALE_W    = 11;
  localparam int DUTY_W     = 7;
  localparam int DRIVE_W    = 2;
  localparam int SCALE_FRAC = 10;
  localparam int DUTY_SHIFT = 3;

  localparam logic [SAMPLE_W-1:0] MIDPOINT    = 10'd511;
  localparam logic [SCALE_W-1:0]  SCALE_ONE   = 11'd1024;
  localparam logic [SCALE_W-1:0]  SCALE_RESET = 11'd51;

  localparam logic [DRIVE_W-1:0] DRIVE_OFF  = 2'd0;
  localparam logic [DRIVE_W-1:0] DRIVE_UP   = 2'd1;
  localparam logic [DRIVE_W-1:0] DRIVE_DOWN = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam sample_t SINE_TBL [SINE_LEN] = '{
    10'd511, 10'd561, 10'd611, 10'd659, 10'd707, 10'd752, 10'd795, 10'd835,
    10'd872, 10'd906, 10'd936, 10'd962, 10'd983, 10'd1000, 10'd1012, 10'd1020,
    10'd1022, 10'd1020, 10'd1012, 10'd1000, 10'd983, 10'd962, 10'd936, 10'd906,
    10'd872, 10'd835, 10'd795, 10'd752, 10'd707, 10'd659, 10'd611, 10'd561,
    10'd511, 10'd461, 10'd411, 10'd363, 10'd315, 10'd270, 10'd227, 10'd187,
    10'd150, 10'd116, 10'd86, 10'd60, 10'd39, 10'd22, 10'd10, 10'd2,
    10'd0, 10'd2, 10'd10, 10'd22, 10'd39, 10'd60, 10'd86, 10'd116,
    10'd150, 10'd187, 10'd227, 10'd270, 10'd315, 10'd363, 10'd411, 10'd461
  };

  typedef struct packed {
    logic [DRIVE_W-1:0] drive_a;
    logic [DRIVE_W-1:0] drive_b;
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/smpd_if.sv =====
`default_nettype none
interface smpd_step_if import smpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STEPS_W-1:0] micro_steps;
  logic               direction;
  modport source (output valid, output micro_steps, output direction, input ready);
  modport sink   (input valid, input micro_steps, input direction, output ready);
endinterface

interface smpd_result_if import smpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] phase_a_drive;
  logic [DRIVE_W-1:0] phase_b_drive;
  logic [DUTY_W-1:0]  duty_a;
  logic [DUTY_W-1:0]  duty_b;
  modport source (output valid, output phase_a_drive, output phase_b_drive,
                  output duty_a, output duty_b, input ready);
  modport sink   (input valid, input phase_a_drive, input phase_b_drive,
                  input duty_a, input duty_b, output ready);
endinterface

interface smpd_cfg_if import smpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/smpd_ptr.sv =====
`default_nettype none
module smpd_ptr import smpd_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF,
  localparam int PW = $clog2(TABLE_POINTS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  output logic                    in_rdy,
  input  wire logic [STEPS_W-1:0] in_steps,
  input  wire logic               in_dir,
  output logic                    dn_vld,
  input  wire logic               dn_rdy,
  output logic [PW-1:0]           dn_ptr_a,
  output logic [PW-1:0]           dn_ptr_b
);

  localparam int EW = (PW + 1 > STEPS_W + 1) ? PW + 1 : STEPS_W + 1;
  localparam logic [EW-1:0] N_E = EW'(TABLE_POINTS);
  localparam logic [PW-1:0] RST_A = PW'(TABLE_POINTS / 4);
  localparam logic [PW-1:0] RST_B = '0;
  localparam logic ENTRY = 1'b0;

  function automatic logic [PW-1:0] move(input logic [PW-1:0] p,
                                         input logic [STEPS_W-1:0] st,
                                         input logic fwd);
    logic [EW-1:0] s;
    logic [EW-1:0] t;
    s = EW'(st);
    for (int k = 0; k < 3; k++) begin
      if (s >= N_E) s = s - N_E;
    end
    if (fwd) t = EW'(p) + s;
    else     t = EW'(p) + N_E - s;
    if (t >= N_E) t = t - N_E;
    return t[PW-1:0];
  endfunction

  // pointer store: one word {a, b}
  logic [2*PW-1:0] ptr_mem [0:0];
  logic [2*PW-1:0] rd_r;
  logic [2*PW-1:0] wdata_r;
  logic [2*PW-1:0] wdata;
  logic [2*PW-1:0] cur;
  logic            init_r, rd_init_r, fwd_r;
  logic            wr_en;

  logic               s1_vld_r;
  logic [STEPS_W-1:0] s1_steps_r;
  logic               s1_dir_r;

  assign wr_en  = s1_vld_r && dn_rdy;
  assign in_rdy = !s1_vld_r || dn_rdy;

  // take the word written last edge, else the store, else the reset pair
  always_comb begin
    if (fwd_r)          cur = wdata_r;
    else if (rd_init_r) cur = rd_r;
    else                cur = {RST_A, RST_B};
  end

  assign dn_ptr_a = move(cur[2*PW-1:PW], s1_steps_r, s1_dir_r);
  assign dn_ptr_b = move(cur[PW-1:0], s1_steps_r, s1_dir_r);
  assign wdata    = {dn_ptr_a, dn_ptr_b};
  assign dn_vld   = s1_vld_r;

  always_ff @(posedge clk) begin
    rd_r <= ptr_mem[ENTRY];
    if (wr_en) begin
      ptr_mem[ENTRY] <= wdata;
      wdata_r        <= wdata;
    end
    if (in_rdy) begin
      s1_steps_r <= in_steps;
      s1_dir_r   <= in_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      init_r    <= 1'b0;
      rd_init_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      if (in_rdy) s1_vld_r <= in_vld;
      if (wr_en)  init_r   <= 1'b1;
      rd_init_r <= init_r;
      fwd_r     <= wr_en;
    end
  end

endmodule
`default_nettype wire

// ===== sv/smpd_duty.sv =====
`default_nettype none
module smpd_duty import smpd_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF,
  localparam int PW = $clog2(TABLE_POINTS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_vld,
  output logic                    up_rdy,
  input  wire logic [PW-1:0]      up_ptr_a,
  input  wire logic [PW-1:0]      up_ptr_b,
  input  wire logic [SCALE_W-1:0] scale,
  output logic                    res_vld,
  input  wire logic               res_rdy,
  output result_t                 res
);

  // idx = floor(ptr * 64 / TABLE_POINTS) via a rounded-up reciprocal
  localparam int SH    = 21;
  localparam int RECIP = ((SINE_LEN << SH) + TABLE_POINTS - 1) / TABLE_POINTS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam int PRW   = PW + RW;
  localparam int MW    = MAG_W + SCALE_W;

  logic            p_vld_r, q_vld_r, r_vld_r, o_vld_r;
  logic            p_rdy, q_rdy, r_rdy, o_rdy;

  logic [PW-1:0]      p_a_r, p_b_r;
  logic [SINE_IW-1:0] q_ia_r, q_ib_r;
  logic [MAG_W-1:0]   r_ma_r, r_mb_r;
  logic [DRIVE_W-1:0] r_da_r, r_db_r;
  result_t            o_res_r;

  logic [PRW-1:0]     prod_a, prod_b;
  logic [MAG_W-1:0]   mag_a, mag_b;
  logic [DRIVE_W-1:0] drv_a, drv_b;
  logic [MW-1:0]      cur_a, cur_b;

  function automatic logic [DRIVE_W+MAG_W-1:0] bridge(input sample_t v);
    logic [DRIVE_W-1:0] d;
    logic [MAG_W-1:0]   m;
    if (v > MIDPOINT) begin
      d = DRIVE_UP;
      m = MAG_W'({v - MIDPOINT, 1'b0});
    end else if (v < MIDPOINT) begin
      d = DRIVE_DOWN;
      m = MAG_W'({MIDPOINT - v, 1'b0});
    end else begin
      d = DRIVE_OFF;
      m = '0;
    end
    return {d, m};
  endfunction

  assign o_rdy  = !o_vld_r || res_rdy;
  assign r_rdy  = !r_vld_r || o_rdy;
  assign q_rdy  = !q_vld_r || r_rdy;
  assign p_rdy  = !p_vld_r || q_rdy;
  assign up_rdy = p_rdy;

  assign prod_a = PRW'(p_a_r) * PRW'(RECIP_V);
  assign prod_b = PRW'(p_b_r) * PRW'(RECIP_V);

  assign {drv_a, mag_a} = bridge(SINE_TBL[q_ia_r]);
  assign {drv_b, mag_b} = bridge(SINE_TBL[q_ib_r]);

  assign cur_a = MW'(r_ma_r) * MW'(scale);
  assign cur_b = MW'(r_mb_r) * MW'(scale);

  always_ff @(posedge clk) begin
    if (p_rdy) begin
      p_a_r <= up_ptr_a;
      p_b_r <= up_ptr_b;
    end
    if (q_rdy) begin
      q_ia_r <= prod_a[SH +: SINE_IW];
      q_ib_r <= prod_b[SH +: SINE_IW];
    end
    if (r_rdy) begin
      r_ma_r <= mag_a;
      r_mb_r <= mag_b;
      r_da_r <= drv_a;
      r_db_r <= drv_b;
    end
    if (o_rdy) begin
      o_res_r.drive_a <= r_da_r;
      o_res_r.drive_b <= r_db_r;
      o_res_r.duty_a  <= cur_a[SCALE_FRAC + DUTY_SHIFT +: DUTY_W];
      o_res_r.duty_b  <= cur_b[SCALE_FRAC + DUTY_SHIFT +: DUTY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      q_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (p_rdy) p_vld_r <= up_vld;
      if (q_rdy) q_vld_r <= p_vld_r;
      if (r_rdy) r_vld_r <= q_vld_r;
      if (o_rdy) o_vld_r <= r_vld_r;
    end
  end

  assign res_vld = o_vld_r;
  assign res     = o_res_r;

endmodule
`default_nettype wire

// ===== sv/sine_microstep_phase_driver.sv =====
`default_nettype none
// Channel   Dir  Payload                                        Moves
// in_step   in   micro_steps[5:0], direction                    one step request
// out_drv   out  phase_a/b_drive[1:0], duty_a/b[6:0]            one result per request
// cfg_wr    in   data[10:0] = current_scale (Q1.10, clamp 1024)  one register write
//
// One request per cycle sustained while out_drv is ready; each result is registered
// through the pointer stage, a pointer register, and the index multiply, sine lookup
// and current-scale multiply stages.
// Reset clears all valid flags and loads current_scale = 51; the pointer store
// reads as the reset pair (A = TABLE_POINTS/4, B = 0) until its first write.
// A stalled output backs up stage by stage; in_step.ready drops only when
// every stage holds a request.
module sine_microstep_phase_driver import smpd_pkg::*; #(
  parameter int TABLE_POINTS = TABLE_POINTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smpd_step_if.sink   in_step,
  smpd_result_if.source out_drv,
  smpd_cfg_if.sink    cfg_wr
);

  localparam int PW = $clog2(TABLE_POINTS);

  logic [SCALE_W-1:0] scale_r;
  logic [SCALE_W-1:0] scale_nxt;

  logic          ptr_vld, ptr_rdy;
  logic [PW-1:0] ptr_a, ptr_b;
  result_t       res;

  // clamp the scale at full current
  assign scale_nxt    = (cfg_wr.data > SCALE_ONE) ? SCALE_ONE : cfg_wr.data;
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr.valid) begin
      scale_r <= scale_nxt;
    end
  end

  // advance both pointers and hold them in the pointer store
  smpd_ptr #(.TABLE_POINTS(TABLE_POINTS)) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_step.valid),
    .in_rdy   (in_step.ready),
    .in_steps (in_step.micro_steps),
    .in_dir   (in_step.direction),
    .dn_vld   (ptr_vld),
    .dn_rdy   (ptr_rdy),
    .dn_ptr_a (ptr_a),
    .dn_ptr_b (ptr_b)
  );

  // look up the sine, set bridge direction and scale the duty
  smpd_duty #(.TABLE_POINTS(TABLE_POINTS)) u_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_vld   (ptr_vld),
    .up_rdy   (ptr_rdy),
    .up_ptr_a (ptr_a),
    .up_ptr_b (ptr_b),
    .scale    (scale_r),
    .res_vld  (out_drv.valid),
    .res_rdy  (out_drv.ready),
    .res      (res)
  );

  assign out_drv.phase_a_drive = res.drive_a;
  assign out_drv.phase_b_drive = res.drive_b;
  assign out_drv.duty_a        = res.duty_a;
  assign out_drv.duty_b        = res.duty_b;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

import smpd_pkg::*;

// Tracks the two coil pointers and the current scale, and holds the coil
// settings that each accepted step request should produce, oldest first.
class coil_scoreboard;
  logic [SINE_IW-1:0] ptr_a;
  logic [SINE_IW-1:0] ptr_b;
  logic [SCALE_W-1:0] scale;
  result_t            pending_drives[$];
  int                 errors;
  int                 checked;

  function new();
    ptr_a   = SINE_IW'(TABLE_POINTS_DEF / 4);
    ptr_b   = '0;
    scale   = SCALE_RESET;
    errors  = 0;
    checked = 0;
  endfunction

  // Bridge direction and PWM level for one coil at table position ptr.
  function automatic void coil_level(input logic [SINE_IW-1:0] ptr,
                                     output logic [DRIVE_W-1:0] drive,
                                     output logic [DUTY_W-1:0] duty);
    int unsigned sample;
    int unsigned mid;
    int unsigned mag;
    int unsigned current;
    sample = 32'(SINE_TBL[ptr]);
    mid    = 32'(MIDPOINT);
    if (sample > mid) begin
      drive = DRIVE_UP;
      mag   = (sample - mid) * 2;
    end else if (sample < mid) begin
      drive = DRIVE_DOWN;
      mag   = (mid - sample) * 2;
    end else begin
      drive = DRIVE_OFF;
      mag   = 0;
    end
    current = (mag * 32'(scale)) >> SCALE_FRAC;
    duty    = DUTY_W'((current >> DUTY_SHIFT) & 32'h7F);
  endfunction

  function void set_scale(input logic [SCALE_W-1:0] value);
    scale = (value > SCALE_ONE) ? SCALE_ONE : value;
  endfunction

  function void note_request(input logic [STEPS_W-1:0] steps, input logic fwd);
    result_t r;
    // Both pointers move together; 6-bit arithmetic wraps modulo 64.
    if (fwd) begin
      ptr_a = ptr_a + steps;
      ptr_b = ptr_b + steps;
    end else begin
      ptr_a = ptr_a - steps;
      ptr_b = ptr_b - steps;
    end
    coil_level(ptr_a, r.drive_a, r.duty_a);
    coil_level(ptr_b, r.drive_b, r.duty_b);
    pending_drives.push_back(r);
  endfunction

  function void check_result(input result_t got);
    result_t exp_r;
    if (pending_drives.size() == 0) begin
      $error("unexpected result: drive_a=%0d drive_b=%0d duty_a=%0d duty_b=%0d",
             got.drive_a, got.drive_b, got.duty_a, got.duty_b);
      errors++;
      return;
    end
    exp_r = pending_drives.pop_front();
    checked++;
    if (got.drive_a !== exp_r.drive_a) begin
      $error("phase_a_drive: expected %0d, got %0d", exp_r.drive_a, got.drive_a);
      errors++;
    end
    if (got.drive_b !== exp_r.drive_b) begin
      $error("phase_b_drive: expected %0d, got %0d", exp_r.drive_b, got.drive_b);
      errors++;
    end
    if (got.duty_a !== exp_r.duty_a) begin
      $error("duty_a: expected %0d, got %0d", exp_r.duty_a, got.duty_a);
      errors++;
    end
    if (got.duty_b !== exp_r.duty_b) begin
      $error("duty_b: expected %0d, got %0d", exp_r.duty_b, got.duty_b);
      errors++;
    end
  endfunction

  function int pending();
    return pending_drives.size();
  endfunction
endclass

module tb_top;

  // Settling margin waited after the scoreboard drains; allow a little more.
  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 148;

  logic clk;
  logic rst_n;

  smpd_step_if   step_ch ();
  smpd_result_if drive_ch ();
  smpd_cfg_if    scale_ch ();

  sine_microstep_phase_driver dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_step (step_ch),
    .out_drv (drive_ch),
    .cfg_wr  (scale_ch)
  );

  coil_scoreboard sb = new();
  int requests_sent  = 0;
  int scale_writes   = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: the slowest legal run stays far below this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Receiver: stall in stretches of varying character, including stretches
  // where ready simply stays high.
  initial begin
    int       mode;
    int       left;
    int       tick;
    bit [7:0] pattern;
    drive_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    pattern = 8'hFF;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode    = $urandom_range(0, 3);
        left    = $urandom_range(8, 80);
        pattern = 8'($urandom()) | 8'h01;
      end
      left--;
      tick++;
      case (mode)
        0: drive_ch.ready = 1'b1;
        1: drive_ch.ready = ($urandom_range(0, 3) != 0);
        2: drive_ch.ready = pattern[tick % 8];
        default: drive_ch.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: take every accepted result at the rising edge and score it.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && drive_ch.valid && drive_ch.ready) begin
      got.drive_a = drive_ch.phase_a_drive;
      got.drive_b = drive_ch.phase_b_drive;
      got.duty_a  = drive_ch.duty_a;
      got.duty_b  = drive_ch.duty_b;
      sb.check_result(got);
    end
  end

  // Present one step request and hold it until the block takes it. Valid
  // stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_step(input logic [STEPS_W-1:0] steps, input logic fwd);
    @(negedge clk);
    step_ch.valid       = 1'b1;
    step_ch.micro_steps = steps;
    step_ch.direction   = fwd;
    do @(posedge clk); while (!step_ch.ready);
    sb.note_request(steps, fwd);
    requests_sent++;
  endtask

  // Drop valid between bursts; n sets how long it stays low.
  task automatic hold_off(input int n);
    @(negedge clk);
    step_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Write the current scale only once the pipeline has drained.
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    @(negedge clk);
    step_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    @(negedge clk);
    scale_ch.valid = 1'b1;
    scale_ch.data  = value;
    do @(posedge clk); while (!scale_ch.ready);
    sb.set_scale(value);
    scale_writes++;
    @(negedge clk);
    scale_ch.valid = 1'b0;
  endtask

  // Random phase: bursts of requests, a third of them small same-direction moves as
  // a rotating motor would see, the rest arbitrary jumps.
  task automatic random_phase(input int count);
    int   sent;
    int   burst;
    logic run_dir;
    logic [STEPS_W-1:0] steps;
    sent    = 0;
    run_dir = 1'($urandom_range(0, 1));
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) run_dir = ~run_dir;
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_step(STEPS_W'($urandom_range(1, 4)), run_dir);
        else begin
          steps = STEPS_W'($urandom_range(0, 63));
          send_step(steps, 1'($urandom_range(0, 1)));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
    end
  endtask

  initial begin
    logic [SCALE_W-1:0] scale_plan[$];
    step_ch.valid       = 1'b0;
    step_ch.micro_steps = '0;
    step_ch.direction   = 1'b0;
    scale_ch.valid      = 1'b0;
    scale_ch.data       = '0;
    rst_n               = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, at the reset scale: zero moves both ways, full-range moves,
    // quarter turns landing on the peak, trough and midpoint (bridge off).
    send_step(6'd0, 1'b1);
    send_step(6'd0, 1'b0);
    send_step(6'd63, 1'b1);
    send_step(6'd63, 1'b0);
    send_step(6'd1, 1'b1);
    send_step(6'd1, 1'b0);
    send_step(6'd16, 1'b1);
    send_step(6'd32, 1'b1);
    send_step(6'd48, 1'b0);
    send_step(6'd21, 1'b0);
    send_step(6'd42, 1'b1);
    hold_off(3);

    // Full scale: largest duty at the peaks.
    write_scale(SCALE_ONE);
    send_step(6'd0, 1'b1);
    send_step(6'd16, 1'b1);
    send_step(6'd16, 1'b0);
    send_step(6'd32, 1'b0);
    send_step(6'd31, 1'b1);

    // Zero scale: drives still follow the table, duty stays at zero.
    write_scale(11'd0);
    send_step(6'd16, 1'b1);
    send_step(6'd5, 1'b0);

    // Above one: the register clamps to full scale.
    write_scale(11'd2047);
    send_step(6'd48, 1'b1);
    send_step(6'd1, 1'b1);

    // Random phases across extremes and arbitrary scales.
    scale_plan = '{11'd1025, 11'd1023, 11'd1, 11'd512, 11'd0, 11'd1024, 11'd2047};
    repeat (3) scale_plan.push_back(SCALE_W'($urandom_range(0, 2047)));
    random_phase(PHASE_ITEMS);
    foreach (scale_plan[i]) begin
      write_scale(scale_plan[i]);
      random_phase(PHASE_ITEMS);
    end

    // Drain and let the pipeline settle.
    @(negedge clk);
    step_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Ran %0d step requests (%0d results scored) over %0d scale writes,",
             requests_sent, sb.checked, scale_writes);
    $display("covering zero, full, clamped and random coil current scales.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
